@@ rtl/mrfe_pkg.sv @@
// Shared types, codes and the CRC-16/MODBUS byte step for the RTU frame engine.
`default_nettype none

package mrfe_pkg;

   localparam int FrameMaxDefault = 256;
   localparam int QueueDepth      = 4;
   localparam int ExpW            = 10;
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;
   localparam logic [7:0]  FcExceptionBit = 8'h80;
   localparam logic [7:0]  FcCodeMask     = 8'h7F;
   localparam logic [7:0]  FcMaxCounted   = 8'h04;

   typedef enum logic [1:0] {
      OP_TX  = 2'd0,
      OP_RX  = 2'd1,
      OP_GAP = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_TX     = 2'd0,
      KIND_PDU    = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_CRC   = 2'd2,
      ST_ADDR  = 2'd3
   } status_type;

   // One queued item's worth of results, handed from front to back.
   typedef struct packed {
      logic        is_tx;
      logic        send_addr;
      logic [7:0]  addr;
      logic [7:0]  data;
      logic        last;
      logic [15:0] crc;
      logic        pdu;
      logic        stat_valid;
      status_type  stat;
   } rec_type;

   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/mrfe_queue.sv @@
// Short FIFO of result records between front and back.
`default_nettype none

module mrfe_queue
   import mrfe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  rec_type      push_rec,
   output logic         full,
   input  wire logic    pop,
   output rec_type      head_rec,
   output logic         empty
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   rec_type             mem_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CntW'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_rec = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

@@ rtl/mrfe_front.sv @@
// Front end: accepts items, runs both CRCs and the receive framing, queues result records.
`default_nettype none

module mrfe_front
   import mrfe_pkg::*;
#(
   parameter int FRAME_MAX = FrameMaxDefault
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_byte,
   input  wire logic        req_last,
   input  wire logic [7:0]  req_addr,
   output logic             push,
   output rec_type          push_rec,
   input  wire logic        q_full
);

   localparam int CntW = $clog2(FRAME_MAX + 1);

   logic [15:0]     tx_crc_ff, tx_crc_in;
   logic            tx_active_ff, tx_active_in;
   logic [7:0]      exp_addr_ff, exp_addr_in;
   logic [15:0]     rx_crc_ff, rx_crc_in;
   logic [CntW-1:0] rx_count_ff, rx_count_in;
   logic [7:0]      hold0_ff, hold0_in;
   logic [7:0]      hold1_ff, hold1_in;
   logic [7:0]      first_ff, first_in;
   logic [7:0]      func_ff, func_in;
   logic [7:0]      bcnt_ff, bcnt_in;
   logic            pend_ff, pend_in;
   logic [7:0]      pend_byte_ff, pend_byte_in;
   logic            pend_last_ff, pend_last_in;

   logic            accept;
   logic [7:0]      tx_byte;
   logic [15:0]     tx_crc_step;
   logic [15:0]     addr_crc;
   logic [15:0]     rx_crc_step;
   logic [CntW-1:0] cnt_new;
   logic [ExpW-1:0] expect_len;
   logic            done;
   status_type      rx_stat;
   status_type      gap_stat;

   assign req_tready = !pend_ff && !q_full;
   assign accept     = req_tvalid && req_tready;

   // The first transmit byte takes two CRC steps: address first, then the held byte.
   assign tx_byte     = pend_ff ? pend_byte_ff : req_byte;
   assign tx_crc_step = crc_add(tx_crc_ff, tx_byte);
   assign addr_crc    = crc_add(CrcInit, req_addr);
   assign rx_crc_step = crc_add(rx_crc_ff, hold0_ff);
   assign cnt_new     = rx_count_ff + CntW'(1);

   always_comb begin
      if ((func_ff & FcExceptionBit) != 8'h00) begin
         expect_len = ExpW'(5);
      end else if ((func_ff & FcCodeMask) <= FcMaxCounted) begin
         expect_len = ExpW'(5) + {{(ExpW-8){1'b0}}, bcnt_ff};
      end else begin
         expect_len = ExpW'(8);
      end
      done = (cnt_new >= CntW'(FRAME_MAX));
      if (cnt_new >= CntW'(5) && ExpW'(cnt_new) >= expect_len) begin
         done = 1'b1;
      end

      // Status as it would stand after this received byte goes in.
      if (cnt_new < CntW'(4)) begin
         rx_stat = ST_SHORT;
      end else if ({req_byte, hold1_ff} != rx_crc_step) begin
         rx_stat = ST_CRC;
      end else if (first_ff != exp_addr_ff) begin
         rx_stat = ST_ADDR;
      end else begin
         rx_stat = ST_OK;
      end

      if (rx_count_ff < CntW'(4)) begin
         gap_stat = ST_SHORT;
      end else if ({hold1_ff, hold0_ff} != rx_crc_ff) begin
         gap_stat = ST_CRC;
      end else if (first_ff != exp_addr_ff) begin
         gap_stat = ST_ADDR;
      end else begin
         gap_stat = ST_OK;
      end
   end

   always_comb begin
      tx_crc_in    = tx_crc_ff;
      tx_active_in = tx_active_ff;
      exp_addr_in  = exp_addr_ff;
      rx_crc_in    = rx_crc_ff;
      rx_count_in  = rx_count_ff;
      hold0_in     = hold0_ff;
      hold1_in     = hold1_ff;
      first_in     = first_ff;
      func_in      = func_ff;
      bcnt_in      = bcnt_ff;
      pend_in      = pend_ff;
      pend_byte_in = pend_byte_ff;
      pend_last_in = pend_last_ff;

      push                = 1'b0;
      push_rec            = '0;
      push_rec.is_tx      = 1'b1;
      push_rec.send_addr  = pend_ff;
      push_rec.addr       = exp_addr_ff;
      push_rec.data       = tx_byte;
      push_rec.last       = pend_ff ? pend_last_ff : req_last;
      push_rec.crc        = tx_crc_step;
      push_rec.stat       = ST_OK;

      if (pend_ff) begin
         if (!q_full) begin
            push         = 1'b1;
            pend_in      = 1'b0;
            tx_crc_in    = pend_last_ff ? CrcInit : tx_crc_step;
            tx_active_in = !pend_last_ff;
         end
      end else if (accept) begin
         case (req_op)
            OP_TX: begin
               if (!tx_active_ff) begin
                  // Start of request: latch address, clear receive side, hold byte.
                  exp_addr_in  = req_addr;
                  tx_crc_in    = addr_crc;
                  tx_active_in = 1'b1;
                  pend_in      = 1'b1;
                  pend_byte_in = req_byte;
                  pend_last_in = req_last;
                  rx_crc_in    = CrcInit;
                  rx_count_in  = '0;
                  hold0_in     = 8'h00;
                  hold1_in     = 8'h00;
                  first_in     = 8'h00;
                  func_in      = 8'h00;
                  bcnt_in      = 8'h00;
               end else begin
                  push         = 1'b1;
                  tx_crc_in    = req_last ? CrcInit : tx_crc_step;
                  tx_active_in = !req_last;
               end
            end
            OP_RX: begin
               push_rec.is_tx      = 1'b0;
               push_rec.send_addr  = 1'b0;
               push_rec.data       = hold0_ff;
               push_rec.pdu        = (rx_count_ff >= CntW'(3));
               push_rec.stat_valid = done;
               push_rec.stat       = rx_stat;
               push                = push_rec.pdu || done;
               if (rx_count_ff == CntW'(0)) first_in = req_byte;
               if (rx_count_ff == CntW'(1)) func_in  = req_byte;
               if (rx_count_ff == CntW'(2)) bcnt_in  = req_byte;
               if (rx_count_ff >= CntW'(2)) rx_crc_in = rx_crc_step;
               hold0_in    = hold1_ff;
               hold1_in    = req_byte;
               rx_count_in = cnt_new;
               if (done) begin
                  rx_crc_in   = CrcInit;
                  rx_count_in = '0;
                  hold0_in    = 8'h00;
                  hold1_in    = 8'h00;
                  first_in    = 8'h00;
                  func_in     = 8'h00;
                  bcnt_in     = 8'h00;
               end
            end
            OP_GAP: begin
               push_rec.is_tx      = 1'b0;
               push_rec.send_addr  = 1'b0;
               push_rec.stat_valid = 1'b1;
               push_rec.stat       = gap_stat;
               push                = 1'b1;
               rx_crc_in   = CrcInit;
               rx_count_in = '0;
               hold0_in    = 8'h00;
               hold1_in    = 8'h00;
               first_in    = 8'h00;
               func_in     = 8'h00;
               bcnt_in     = 8'h00;
            end
            default: begin
               // Unused operation code: drop.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_crc_ff    <= CrcInit;
         tx_active_ff <= 1'b0;
         exp_addr_ff  <= 8'h00;
         rx_crc_ff    <= CrcInit;
         rx_count_ff  <= '0;
         hold0_ff     <= 8'h00;
         hold1_ff     <= 8'h00;
         first_ff     <= 8'h00;
         func_ff      <= 8'h00;
         bcnt_ff      <= 8'h00;
         pend_ff      <= 1'b0;
      end else begin
         tx_crc_ff    <= tx_crc_in;
         tx_active_ff <= tx_active_in;
         exp_addr_ff  <= exp_addr_in;
         rx_crc_ff    <= rx_crc_in;
         rx_count_ff  <= rx_count_in;
         hold0_ff     <= hold0_in;
         hold1_ff     <= hold1_in;
         first_ff     <= first_in;
         func_ff      <= func_in;
         bcnt_ff      <= bcnt_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      pend_last_ff <= pend_last_in;
   end

endmodule

`default_nettype wire

@@ rtl/mrfe_back.sv @@
// Back end: expands each queued record into result items through an output register.
`default_nettype none

module mrfe_back
   import mrfe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  rec_type          head_rec,
   input  wire logic        q_empty,
   output logic             pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_byte,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);

   logic [1:0]  step_ff, step_in;
   logic        valid_ff, valid_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   status_type  stat_ff, stat_in;
   logic        last_ff, last_in;

   logic        load;
   logic [1:0]  last_step;
   logic [1:0]  sel;

   assign load = !q_empty && (!valid_ff || rsp_tready);

   always_comb begin
      kind_in = KIND_TX;
      byte_in = 8'h00;
      stat_in = ST_OK;
      last_in = 1'b0;
      sel     = 2'd0;
      if (head_rec.is_tx) begin
         last_step = {head_rec.last, head_rec.send_addr};
         // Skip the address slot when this is not the first byte.
         sel = step_ff + {1'b0, !head_rec.send_addr};
         case (sel)
            2'd0: byte_in = head_rec.addr;
            2'd1: byte_in = head_rec.data;
            2'd2: byte_in = head_rec.crc[7:0];
            default: begin
               byte_in = head_rec.crc[15:8];
               last_in = 1'b1;
            end
         endcase
      end else begin
         last_step = {1'b0, head_rec.pdu && head_rec.stat_valid};
         if (step_ff == 2'd0 && head_rec.pdu) begin
            kind_in = KIND_PDU;
            byte_in = head_rec.data;
         end else begin
            kind_in = KIND_STATUS;
            stat_in = head_rec.stat;
            last_in = 1'b1;
         end
      end

      pop      = load && (step_ff == last_step);
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_tready;
      if (load) begin
         valid_in = 1'b1;
         step_in  = pop ? 2'd0 : step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         stat_ff <= stat_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_status = stat_ff;
   assign rsp_last   = last_ff;

endmodule

`default_nettype wire

@@ rtl/modbus_rtu_frame_engine.sv @@
// Top level of the Modbus RTU master frame engine.
//
//  channel  direction  tdata                                tuser          tlast
//  req_     in         [7:0] data_byte, [15:8] slave_addr   operation      last_byte
//  rsp_     out        [7:0] out_byte, [9:8] status         kind           last_out
//
// An item is taken every cycle while the record queue has room and no first byte is pending;
// the first byte of a request goes through the front as an address CRC step, then a byte CRC step.
// The back end sends one result item a cycle while rsp_tready is not held low, and each accepted
// item causes 0 to 4 result items at the output.
// Synchronous active-high reset clears framing state, the queue and the output valid flag.
// The queue lets the front keep taking items while the output side stalls.
`default_nettype none

module modbus_rtu_frame_engine
   import mrfe_pkg::*;
#(
   parameter int FRAME_MAX = FrameMaxDefault
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] slave_address
   input  wire logic [1:0]  req_tuser,   // [1:0] operation
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_byte, [9:8] status, rest zero
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast
);

   logic     push, q_full, q_empty, pop;
   rec_type  push_rec, head_rec;
   logic [7:0] out_byte;
   logic [1:0] out_status;

   mrfe_front #(
      .FRAME_MAX (FRAME_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_byte   (req_tdata[7:0]),
      .req_last   (req_tlast),
      .req_addr   (req_tdata[15:8]),
      .push       (push),
      .push_rec   (push_rec),
      .q_full     (q_full)
   );

   mrfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .full     (q_full),
      .pop      (pop),
      .head_rec (head_rec),
      .empty    (q_empty)
   );

   mrfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_rec   (head_rec),
      .q_empty    (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_byte   (out_byte),
      .rsp_status (out_status),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'b000000, out_status, out_byte};

endmodule

`default_nettype wire
